// File: hw/rtl/process_state_priority_scheduler_top_assert.svh
// Assertion macros for the scheduler top level.
`ifndef PROCESS_STATE_PRIORITY_SCHEDULER_TOP_ASSERT_SVH
`define PROCESS_STATE_PRIORITY_SCHEDULER_TOP_ASSERT_SVH
// An implication checked on every clock, skipped in reset.
`define PSPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// A condition checked in the cycle after the antecedent, skipped in reset.
`define PSPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// File: hw/rtl/psps_pkg.sv
// ---------------------------------------------------------------------------
// psps_pkg
// Types and constants shared by the process scheduler.
// ---------------------------------------------------------------------------
package psps_pkg;
    localparam int MaxProcs = 16;
    localparam int SlotW    = $clog2(MaxProcs);
    localparam int CntW     = $clog2(MaxProcs + 1);
    localparam int MemW     = 10;
    localparam int IdW      = 8;
    localparam int PrioW    = 8;
    localparam int OrdW     = 16;
    localparam logic [MemW-1:0] MemReset = MemW'(100);
    localparam logic [MemW-1:0] MemMax   = '1;
    localparam logic [OrdW-1:0] OrdLimit = '1;

    typedef enum logic [2:0] {
        OP_DISPATCH = 3'd0, OP_TIMEOUT = 3'd1, OP_WAIT = 3'd2, OP_OCCUR = 3'd3,
        OP_CREATE = 3'd4, OP_ADMIT = 3'd5, OP_RELEASE = 3'd6, OP_NONE = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_NONE_RUN = 3'd1, ST_ALREADY = 3'd2, ST_READY_EMPTY = 3'd3,
        ST_NOT_BLOCKED = 3'd4, ST_NEW_EMPTY = 3'd5, ST_MEM_EXCEED = 3'd6,
        ST_TABLE_FULL = 3'd7
    } t_status;

    typedef enum logic [2:0] {
        PS_FREE = 3'd0, PS_NEW = 3'd1, PS_READY = 3'd2, PS_RUN = 3'd3, PS_BLOCK = 3'd4
    } t_pstate;

    // Scan request into the search unit.
    typedef struct packed {
        logic     start;
        logic [1:0] mode;   // 0 best prio, 1 id match, 2 first free, 3 rank
        t_pstate  list;
        logic [IdW-1:0]  id;
        logic [OrdW-1:0] ord;
    } t_scan_req;

    typedef struct packed {
        logic             done;
        logic             found;
        logic [SlotW-1:0] slot;
        logic [CntW-1:0]  count;
    } t_scan_rsp;

    localparam logic [1:0] SM_BEST = 2'd0;
    localparam logic [1:0] SM_ID   = 2'd1;
    localparam logic [1:0] SM_FREE = 2'd2;
    localparam logic [1:0] SM_RANK = 2'd3;

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_SCAN_RDY, S_DISP, S_STOP, S_OCC_SCAN, S_OCC_DONE,
        S_CR_SCAN, S_CR_DONE, S_AD_SCAN, S_AD_DONE, S_REL, S_REL_SCAN, S_REL_DONE,
        S_ENTER, S_RN_SCAN, S_RN_STEP, S_RN_APPLY, S_OUT
    } t_fsm;
endpackage

// File: hw/rtl/psps_scan.sv
// ---------------------------------------------------------------------------
// psps_scan
// Sequential table scanner: one entry per cycle over all slots.
// ---------------------------------------------------------------------------
module psps_scan (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  psps_pkg::t_scan_req                        i_req,
    input  psps_pkg::t_pstate [psps_pkg::MaxProcs-1:0] i_state,
    input  logic [psps_pkg::MaxProcs-1:0][psps_pkg::IdW-1:0]   i_ident,
    input  logic [psps_pkg::MaxProcs-1:0][psps_pkg::PrioW-1:0] i_prio,
    input  logic [psps_pkg::MaxProcs-1:0][psps_pkg::OrdW-1:0]  i_order,
    output psps_pkg::t_scan_rsp                        o_rsp
);
    import psps_pkg::*;

    logic             r_busy, n_busy;
    logic [SlotW-1:0] r_idx, n_idx;
    logic             r_found, n_found;
    logic [SlotW-1:0] r_best, n_best;
    logic [CntW-1:0]  r_cnt, n_cnt;
    logic             r_done, n_done;
    t_scan_req        r_req;
    logic             hit, better, live;
    logic [PrioW-1:0] c_prio, b_prio;
    logic [OrdW-1:0]  c_ord, b_ord;

    always_comb begin
        c_prio = i_prio[r_idx];
        b_prio = i_prio[r_best];
        c_ord  = i_order[r_idx];
        b_ord  = i_order[r_best];
        live   = i_state[r_idx] != PS_FREE;
        hit    = 1'b0;
        better = 1'b0;
        unique case (r_req.mode)
            SM_BEST: begin
                hit    = i_state[r_idx] == r_req.list;
                better = !r_found || c_prio < b_prio || (c_prio == b_prio && c_ord < b_ord);
            end
            SM_ID: begin
                hit    = i_state[r_idx] == PS_BLOCK && i_ident[r_idx] == r_req.id;
                better = !r_found || c_ord < b_ord;
            end
            SM_FREE: begin
                hit    = i_state[r_idx] == PS_FREE;
                better = !r_found;
            end
            SM_RANK: begin
                hit    = live && c_ord < r_req.ord;
                better = 1'b0;
            end
            default: ;
        endcase
        n_busy  = r_busy;
        n_idx   = r_idx;
        n_found = r_found;
        n_best  = r_best;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        if (i_req.start) begin
            n_busy  = 1'b1;
            n_idx   = '0;
            n_found = 1'b0;
            n_best  = '0;
            n_cnt   = '0;
        end else if (r_busy) begin
            if (hit && better) begin
                n_found = 1'b1;
                n_best  = r_idx;
            end
            if (r_req.mode == SM_RANK && hit) n_cnt = r_cnt + CntW'(1);
            if (r_req.mode == SM_RANK && live) n_found = 1'b1;
            if (r_idx == SlotW'(MaxProcs - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_idx = r_idx + SlotW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_idx   <= n_idx;
        r_found <= n_found;
        r_best  <= n_best;
        r_cnt   <= n_cnt;
        if (i_req.start) r_req <= i_req;
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.found = r_found;
    assign o_rsp.slot  = r_best;
    assign o_rsp.count = r_cnt;
endmodule

// File: hw/rtl/process_state_priority_scheduler_top.sv
// ---------------------------------------------------------------------------
// process_state_priority_scheduler_top
// Process table with priority dispatch, blocking and memory accounting.
// ---------------------------------------------------------------------------
// Channel   Dir  Fields (low bit first)
// s_axis    in   tdata: op[2:0] proc_id[10:3] proc_mem[20:11] proc_prio[28:21]
// m_axis    out  tdata: status[2:0] running_valid[3] running_id[11:4] free_mem[21:12]
// cfg       in   i_cfg_data: total_memory
// Each table scan walks all 16 slots, one per cycle. Before the order counter
// wraps, the order stamps are renumbered by 16 rank scans, one per slot.
// Input ready only when idle and no result is pending; the result sits in an output register until taken.
// Reset is synchronous; the table comes up all free, free memory at 100.
module process_state_priority_scheduler_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // op, proc_id, proc_mem, proc_prio
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // status, running_valid, running_id, free_mem
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [psps_pkg::MemW-1:0] i_cfg_data
);
    import psps_pkg::*;

    t_fsm r_fsm, n_fsm, r_ret, n_ret;
    t_pstate [MaxProcs-1:0] r_state;
    logic [MaxProcs-1:0][IdW-1:0]   r_ident;
    logic [MaxProcs-1:0][MemW-1:0]  r_mem;
    logic [MaxProcs-1:0][PrioW-1:0] r_prio;
    logic [MaxProcs-1:0][OrdW-1:0]  r_order;
    logic [OrdW-1:0]  r_ocnt;
    logic [MemW-1:0]  r_free;
    logic             r_run_v;
    logic [SlotW-1:0] r_run;
    t_op              r_op;
    logic [IdW-1:0]   r_pid;
    logic [MemW-1:0]  r_pmem;
    logic [PrioW-1:0] r_pprio;
    t_status          r_stat;
    logic             r_ovalid;
    logic [23:0]      r_odata;
    logic [SlotW-1:0] r_eslot;
    t_pstate          r_elist;
    logic [SlotW-1:0] r_ri;
    logic [CntW-1:0]  r_rn;
    logic [MaxProcs-1:0][OrdW-1:0] r_rank;

    t_scan_req sreq;
    t_scan_rsp srsp;
    logic [MemW:0] sum;

    psps_scan u_scan (
        .i_clk, .i_rst_n, .i_req(sreq), .i_state(r_state), .i_ident(r_ident),
        .i_prio(r_prio), .i_order(r_order), .o_rsp(srsp)
    );

    assign s_axis_tready = r_fsm == S_IDLE && !r_ovalid;
    assign o_cfg_ready   = r_fsm == S_IDLE;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign sum = {1'b0, r_free} + {1'b0, r_mem[r_run]};

    always_comb begin
        n_fsm = r_fsm;
        n_ret = r_ret;
        sreq  = '{start: 1'b0, mode: SM_BEST, list: PS_READY, id: r_pid,
                  ord: r_order[r_ri]};
        unique case (r_fsm)
            S_IDLE: if (s_axis_tvalid && s_axis_tready) n_fsm = S_DECODE;
            S_DECODE: begin
                unique case (r_op)
                    OP_DISPATCH: begin
                        if (r_run_v) n_fsm = S_OUT;
                        else begin sreq.start = 1'b1; n_fsm = S_SCAN_RDY; end
                    end
                    OP_TIMEOUT, OP_WAIT: n_fsm = r_run_v ? S_STOP : S_OUT;
                    OP_OCCUR: begin
                        sreq.start = 1'b1; sreq.mode = SM_ID; n_fsm = S_OCC_SCAN;
                    end
                    OP_CREATE: begin
                        sreq.start = 1'b1; sreq.mode = SM_FREE; n_fsm = S_CR_SCAN;
                    end
                    OP_ADMIT: begin
                        sreq.start = 1'b1; sreq.list = PS_NEW; n_fsm = S_AD_SCAN;
                    end
                    OP_RELEASE: n_fsm = r_run_v ? S_REL : S_OUT;
                    default: n_fsm = S_OUT;
                endcase
            end
            S_SCAN_RDY: if (srsp.done) n_fsm = S_DISP;
            S_DISP: n_fsm = S_OUT;
            S_STOP: begin n_fsm = S_ENTER; n_ret = S_SCAN_RDY; end
            S_OCC_SCAN: if (srsp.done) n_fsm = S_OCC_DONE;
            S_OCC_DONE: begin n_fsm = srsp.found ? S_ENTER : S_OUT; n_ret = S_OUT; end
            S_CR_SCAN: if (srsp.done) n_fsm = S_CR_DONE;
            S_CR_DONE: begin n_fsm = srsp.found ? S_ENTER : S_OUT; n_ret = S_OUT; end
            S_AD_SCAN: if (srsp.done) n_fsm = S_AD_DONE;
            S_AD_DONE: begin n_fsm = r_elist == PS_READY ? S_ENTER : S_OUT; n_ret = S_OUT; end
            S_REL: begin
                sreq.start = 1'b1; sreq.list = PS_NEW; n_fsm = S_REL_SCAN;
            end
            S_REL_SCAN: if (srsp.done) n_fsm = S_REL_DONE;
            S_REL_DONE: begin
                n_ret = S_SCAN_RDY;
                n_fsm = r_elist == PS_READY ? S_ENTER : S_SCAN_RDY;
                if (r_elist != PS_READY) sreq.start = 1'b1;
            end
            S_ENTER: begin
                if (r_ocnt == OrdLimit) n_fsm = S_RN_STEP;
                else begin
                    n_fsm = r_ret;
                    if (r_ret == S_SCAN_RDY) sreq.start = 1'b1;
                end
            end
            S_RN_STEP: begin
                sreq.start = 1'b1; sreq.mode = SM_RANK; n_fsm = S_RN_SCAN;
            end
            S_RN_SCAN: if (srsp.done) begin
                n_fsm = r_ri == SlotW'(MaxProcs - 1) ? S_RN_APPLY : S_RN_STEP;
            end
            S_RN_APPLY: n_fsm = S_ENTER;
            S_OUT: n_fsm = S_IDLE;
            default: n_fsm = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm    <= S_IDLE;
            r_ret    <= S_OUT;
            r_state  <= {MaxProcs{PS_FREE}};
            r_ocnt   <= '0;
            r_free   <= MemReset;
            r_run_v  <= 1'b0;
            r_run    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_fsm <= n_fsm;
            r_ret <= n_ret;
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) r_free <= i_cfg_data;
            unique case (r_fsm)
                S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    r_op    <= t_op'(s_axis_tdata[2:0]);
                    r_pid   <= s_axis_tdata[10:3];
                    r_pmem  <= s_axis_tdata[20:11];
                    r_pprio <= s_axis_tdata[28:21];
                end
                S_DECODE: begin
                    unique case (r_op)
                        OP_DISPATCH: r_stat <= r_run_v ? ST_ALREADY : ST_OK;
                        OP_TIMEOUT, OP_WAIT, OP_RELEASE:
                            r_stat <= r_run_v ? ST_OK : ST_NONE_RUN;
                        default: r_stat <= ST_OK;
                    endcase
                end
                S_SCAN_RDY: ;
                S_DISP: begin
                    if (srsp.found) begin
                        r_state[srsp.slot] <= PS_RUN;
                        r_run   <= srsp.slot;
                        r_run_v <= 1'b1;
                    end else if (r_op == OP_DISPATCH) r_stat <= ST_READY_EMPTY;
                end
                S_STOP: begin
                    r_eslot <= r_run;
                    r_elist <= r_op == OP_TIMEOUT ? PS_READY : PS_BLOCK;
                    r_run_v <= 1'b0;
                    r_run   <= '0;
                end
                S_OCC_DONE: begin
                    r_eslot <= srsp.slot;
                    r_elist <= PS_READY;
                    if (!srsp.found) r_stat <= ST_NOT_BLOCKED;
                end
                S_CR_DONE: begin
                    r_eslot <= srsp.slot;
                    if (!srsp.found) r_stat <= ST_TABLE_FULL;
                    else begin
                        r_ident[srsp.slot] <= r_pid;
                        r_mem[srsp.slot]   <= r_pmem;
                        r_prio[srsp.slot]  <= r_pprio;
                        if (r_pmem <= r_free) begin
                            r_free  <= r_free - r_pmem;
                            r_elist <= PS_READY;
                        end else begin
                            r_elist <= PS_NEW;
                            r_stat  <= ST_MEM_EXCEED;
                        end
                    end
                end
                S_AD_SCAN, S_REL_SCAN: if (srsp.done) begin
                    r_eslot <= srsp.slot;
                    if (srsp.found && r_mem[srsp.slot] <= r_free) begin
                        r_free  <= r_free - r_mem[srsp.slot];
                        r_elist <= PS_READY;
                    end else begin
                        r_elist <= PS_FREE;
                        if (r_op == OP_ADMIT)
                            r_stat <= srsp.found ? ST_MEM_EXCEED : ST_NEW_EMPTY;
                    end
                end
                S_REL: begin
                    r_free  <= sum[MemW] ? MemMax : sum[MemW-1:0];
                    r_state[r_run] <= PS_FREE;
                    r_run_v <= 1'b0;
                    r_run   <= '0;
                end
                S_ENTER: begin
                    if (r_ocnt == OrdLimit) r_ri <= '0;
                    else begin
                        r_order[r_eslot] <= r_ocnt;
                        r_ocnt           <= r_ocnt + OrdW'(1);
                        r_state[r_eslot] <= r_elist;
                    end
                    r_rn <= '0;
                end
                S_RN_SCAN: if (srsp.done) begin
                    r_rank[r_ri] <= OrdW'(srsp.count);
                    if (r_state[r_ri] != PS_FREE) r_rn <= r_rn + CntW'(1);
                    r_ri <= r_ri + SlotW'(1);
                end
                S_RN_APPLY: begin
                    for (int k = 0; k < MaxProcs; k++)
                        if (r_state[k] != PS_FREE) r_order[k] <= r_rank[k];
                    r_ocnt <= OrdW'(r_rn);
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_odata  <= {2'b00, r_free, r_run_v ? r_ident[r_run] : IdW'(0),
                                 r_run_v, r_stat};
                end
                default: ;
            endcase
        end
    end

    `include "process_state_priority_scheduler_top_assert.svh"

    `PSPS_ASSERT_IMP(a_run_state, i_clk, i_rst_n, r_run_v && r_fsm == S_IDLE,
        r_state[r_run] == PS_RUN, "running slot not in run state")
    `PSPS_ASSERT_IMP(a_busy_ready, i_clk, i_rst_n, r_fsm != S_IDLE,
        !s_axis_tready, "ready while busy")
    `PSPS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid, "result dropped")
endmodule
